/* rtl/core/bppg_pkg.sv */
// Shared types and constants of the Bezier path point generator.
package bppg_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } bppg_state_t;

  typedef logic [4:0] bppg_op_t;

  // Multiplier schedule, issued one per cycle in this order.
  localparam bppg_op_t OP_NN   = 5'd0;
  localparam bppg_op_t OP_MM   = 5'd1;
  localparam bppg_op_t OP_MK   = 5'd2;
  localparam bppg_op_t OP_KK   = 5'd3;
  localparam bppg_op_t OP_D    = 5'd4;
  localparam bppg_op_t OP_W0   = 5'd5;
  localparam bppg_op_t OP_W1   = 5'd6;
  localparam bppg_op_t OP_W2   = 5'd7;
  localparam bppg_op_t OP_W3   = 5'd8;
  localparam bppg_op_t OP_X0   = 5'd9;
  localparam bppg_op_t OP_X1   = 5'd10;
  localparam bppg_op_t OP_X2   = 5'd11;
  localparam bppg_op_t OP_X3   = 5'd12;
  localparam bppg_op_t OP_Y0   = 5'd13;
  localparam bppg_op_t OP_Y1   = 5'd14;
  localparam bppg_op_t OP_Y2   = 5'd15;
  localparam bppg_op_t OP_Y3   = 5'd16;
  localparam bppg_op_t OP_LAST = OP_Y3;

  localparam logic [10:0] STEPS_MIN = 11'd2;
  localparam logic [10:0] STEPS_MAX = 11'd1024;
  localparam logic [10:0] STEPS_RST = 11'd32;

  typedef struct packed {
    logic     accept;
    logic     mul_start;
    logic     mul_issue;
    bppg_op_t op;
    logic     div_start;
    logic     div_step;
    logic     out_load;
  } bppg_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_end;
  } bppg_status_t;

endpackage

/* rtl/core/bppg_ctrl.sv */
// Sequencer for the Bezier path point generator.
module bppg_ctrl import bppg_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  bppg_status_t status,
  output bppg_cmd_t    cmd
);

  localparam logic [5:0] DIV_LAST = 6'(COORD_WIDTH);
  localparam logic [5:0] MUL_END  = 6'(OP_LAST) + 6'd1;

  bppg_state_t state, state_next;
  logic [5:0]  cnt, cnt_next;
  logic        m_tvalid_next;
  logic        out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    m_tvalid_next = m_tvalid && !m_tready;
    cmd           = '0;
    cmd.op        = bppg_op_t'(cnt);
    s_tready      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.is_start) begin
          state_next = ST_IDLE;
        end else if (status.is_end) begin
          state_next = ST_OUT;
        end else begin
          cmd.mul_start = 1'b1;
          cnt_next      = '0;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        // The last cycle only retires the final product.
        cmd.mul_issue = (cnt != MUL_END);
        if (cnt == MUL_END) begin
          cnt_next   = '0;
          state_next = ST_DIV;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_DIV: begin
        cmd.div_start = (cnt == 6'd0);
        cmd.div_step  = (cnt != 6'd0);
        if (cnt == DIV_LAST) begin
          state_next = ST_OUT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> m_tvalid)
    else $error("result not presented after load");
  a_mul_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt <= MUL_END))
    else $error("multiply schedule overran");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !cmd.out_load)
    else $error("pending result overwritten");
`endif

endmodule

/* rtl/core/bppg_dp.sv */
// Datapath: control points, shared multiplier, accumulators and dividers.
module bppg_dp import bppg_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  bppg_cmd_t     cmd,
  input  logic [10:0]   n_eff,
  input  logic          in_op,
  input  logic [127:0]  in_data,
  output bppg_status_t  status,
  output logic [15:0]   point_x,
  output logic [15:0]   point_y,
  output logic          segment_end
);

  localparam int CW = COORD_WIDTH;

  logic [CW-1:0] px [5];
  logic [CW-1:0] py [5];
  logic [10:0]   k;
  logic [10:0]   kinc;
  logic [10:0]   m;
  logic [CW-1:0] sx, sy, fx, fy, cx, cy, ex, ey, midx, midy;

  logic [31:0] nn, mm, mk, kk, d, w0, w1, w2, w3;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic        wb_valid;
  bppg_op_t    wb_op;
  logic [63:0] acc_x, acc_y;
  logic [63:0] sh_x, sh_y;
  logic [32:0] rem_x, rem_y, t_x, t_y;
  logic [CW-1:0] low_x, low_y;

  assign sx = CW'(in_data[15:0]);
  assign sy = CW'(in_data[31:16]);
  assign fx = CW'(in_data[47:32]);
  assign fy = CW'(in_data[63:48]);
  assign cx = CW'(in_data[79:64]);
  assign cy = CW'(in_data[95:80]);
  assign ex = CW'(in_data[111:96]);
  assign ey = CW'(in_data[127:112]);
  assign midx = CW'(({1'b0, cx} + {1'b0, ex}) >> 1);
  assign midy = CW'(({1'b0, cy} + {1'b0, ey}) >> 1);
  assign kinc = k + 11'd1;
  assign m    = n_eff - k;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        px[i] <= '0;
        py[i] <= '0;
      end
      k      <= '0;
      status <= '0;
    end else if (cmd.accept) begin
      if (!in_op) begin
        px[0] <= sx; py[0] <= sy;
        px[1] <= fx; py[1] <= fy;
        px[2] <= cx; py[2] <= cy;
        px[4] <= ex; py[4] <= ey;
        px[3] <= midx; py[3] <= midy;
        k <= '0;
        status <= '{is_start: 1'b1, is_end: 1'b0};
      end else if (kinc == n_eff) begin
        k <= kinc;
        status <= '{is_start: 1'b0, is_end: 1'b1};
      end else if (kinc > n_eff) begin
        // Chain a new segment from the old end point and far point.
        px[0] <= px[3]; py[0] <= py[3];
        px[1] <= px[4]; py[1] <= py[4];
        px[2] <= cx; py[2] <= cy;
        px[4] <= ex; py[4] <= ey;
        px[3] <= midx; py[3] <= midy;
        k <= 11'd1;
        status <= '0;
      end else begin
        k <= kinc;
        status <= '0;
      end
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.op)
      OP_NN: begin op_a = 32'(n_eff); op_b = 32'(n_eff); end
      OP_MM: begin op_a = 32'(m);     op_b = 32'(m);     end
      OP_MK: begin op_a = 32'(m);     op_b = 32'(k);     end
      OP_KK: begin op_a = 32'(k);     op_b = 32'(k);     end
      OP_D:  begin op_a = nn;         op_b = 32'(n_eff); end
      OP_W0: begin op_a = mm;         op_b = 32'(m);     end
      OP_W1: begin op_a = mm;         op_b = 32'(k);     end
      OP_W2: begin op_a = mk;         op_b = 32'(k);     end
      OP_W3: begin op_a = kk;         op_b = 32'(k);     end
      OP_X0: begin op_a = w0; op_b = 32'(px[0]); end
      OP_X1: begin op_a = w1; op_b = 32'(px[1]); end
      OP_X2: begin op_a = w2; op_b = 32'(px[2]); end
      OP_X3: begin op_a = w3; op_b = 32'(px[3]); end
      OP_Y0: begin op_a = w0; op_b = 32'(py[0]); end
      OP_Y1: begin op_a = w1; op_b = 32'(py[1]); end
      OP_Y2: begin op_a = w2; op_b = 32'(py[2]); end
      OP_Y3: begin op_a = w3; op_b = 32'(py[3]); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= cmd.mul_issue;
    end
  end

  always_ff @(posedge clk) begin
    prod  <= op_a * op_b;
    wb_op <= cmd.op;
    if (cmd.mul_start) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (wb_valid) begin
      case (wb_op)
        OP_NN: nn <= prod[31:0];
        OP_MM: mm <= prod[31:0];
        OP_MK: mk <= prod[31:0];
        OP_KK: kk <= prod[31:0];
        OP_D:  d  <= prod[31:0];
        OP_W0: w0 <= prod[31:0];
        OP_W1: w1 <= prod[31:0] + {prod[30:0], 1'b0};
        OP_W2: w2 <= prod[31:0] + {prod[30:0], 1'b0};
        OP_W3: w3 <= prod[31:0];
        OP_X0, OP_X1, OP_X2, OP_X3: acc_x <= acc_x + prod;
        OP_Y0, OP_Y1, OP_Y2, OP_Y3: acc_y <= acc_y + prod;
        default: ;
      endcase
    end
  end

  // Restoring division by N cubed; the quotient always fits a coordinate.
  assign sh_x = acc_x >> CW;
  assign sh_y = acc_y >> CW;
  assign t_x  = {rem_x[31:0], low_x[CW-1]};
  assign t_y  = {rem_y[31:0], low_y[CW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_x <= sh_x[32:0];
      rem_y <= sh_y[32:0];
      low_x <= acc_x[CW-1:0];
      low_y <= acc_y[CW-1:0];
    end else if (cmd.div_step) begin
      if (t_x >= {1'b0, d}) begin
        rem_x <= t_x - {1'b0, d};
        low_x <= {low_x[CW-2:0], 1'b1};
      end else begin
        rem_x <= t_x;
        low_x <= {low_x[CW-2:0], 1'b0};
      end
      if (t_y >= {1'b0, d}) begin
        rem_y <= t_y - {1'b0, d};
        low_y <= {low_y[CW-2:0], 1'b1};
      end else begin
        rem_y <= t_y;
        low_y <= {low_y[CW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (status.is_end) begin
        point_x <= 16'(px[3]);
        point_y <= 16'(py[3]);
      end else begin
        point_x <= 16'(low_x);
        point_y <= 16'(low_y);
      end
      segment_end <= status.is_end;
    end
  end

endmodule

/* rtl/core/bezier_path_point_generator_unit.sv */
// Sequence: a start beat is only decoded and gives no result; an end point's beat is decoded and
// then loaded into the output register. An interior point is decoded, then runs its products on
// the single shared 32x32 multiplier, then a load of the divider and COORD_WIDTH restoring divide
// steps, and is then loaded into the output register.
// Throughput: one beat in work at a time; the next beat is taken as soon as the last is handed
// to the output register, even while that result still waits for m_tready.
// Reset (rst, synchronous, active high): points and step counter zero, N back to 32.
module bezier_path_point_generator_unit import bppg_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  // Input beat.
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, first_ctrl_x, first_ctrl_y, new_ctrl_x, new_ctrl_y,
  // new_far_x, new_far_y (16 bits each, lowest first).
  input  logic [127:0] s_tdata,
  // operation: 0 starts a path, 1 requests the next point.
  input  logic         s_tuser,
  // Result beat.
  output logic         m_tvalid,
  input  logic         m_tready,
  // point_x, point_y (16 bits each, lowest first).
  output logic [31:0]  m_tdata,
  // segment_end.
  output logic         m_tuser,
  // Configuration port, one register: steps_per_segment at address 0.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [10:0]  steps_per_segment;
  logic [10:0]  n_eff;
  bppg_cmd_t    cmd;
  bppg_status_t status;
  logic [15:0]  point_x, point_y;

  // With a single register every address decodes to it.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(steps_per_segment) : 32'(steps_per_segment);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_segment <= STEPS_RST;
    end else if (psel && penable && pwrite && pready) begin
      steps_per_segment <= pwdata[10:0];
    end
  end

  // The step count in use is saturated into its legal range.
  always_comb begin
    if (steps_per_segment < STEPS_MIN) begin
      n_eff = STEPS_MIN;
    end else if (steps_per_segment > STEPS_MAX) begin
      n_eff = STEPS_MAX;
    end else begin
      n_eff = steps_per_segment;
    end
  end

  bppg_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bppg_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .n_eff       (n_eff),
    .in_op       (s_tuser),
    .in_data     (s_tdata),
    .status      (status),
    .point_x     (point_x),
    .point_y     (point_y),
    .segment_end (m_tuser)
  );

  assign m_tdata = {point_y, point_x};

endmodule

/* test/tb.sv */
// Self-checking testbench for the Bezier path point generator unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bppg_pkg::*;

  // One input beat. The hold flag makes the driver wait before this beat
  // until every point that was predicted earlier has come out.
  typedef struct {
    logic        is_next;
    logic [15:0] sx, sy, c1x, c1y, c2x, c2y, fx, fy;
    logic        hold;
  } path_req_t;

  typedef struct {
    logic [15:0] x, y;
    logic        seg_end;
  } path_point_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;
  logic         m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [1:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  bezier_path_point_generator_unit uut (.*);

  always #4 clk = ~clk;

  // Pending input beats and the points they are predicted to produce.
  path_req_t   req_q[$];
  path_point_t point_q[$];

  // The testbench's own copy of the generator state.
  logic [15:0] cp_x[5];
  logic [15:0] cp_y[5];
  logic [10:0] step_k;
  logic [10:0] steps_reg;

  int unsigned sender_idle = 0;
  int unsigned receiver_idle = 0;
  int mismatches = 0;
  int points_seen = 0;
  int ends_seen = 0;
  int starts_sent = 0;

  // Weighted Bernstein sum of one axis, divided by N cubed and floored.
  function automatic logic [15:0] bezier_axis(input logic [15:0] p[5],
                                              input logic [63:0] n, input logic [63:0] k);
    logic [63:0] m;
    logic [63:0] sum;
    m = n - k;
    sum = m * m * m * p[0] + 3 * m * m * k * p[1] + 3 * m * k * k * p[2] + k * k * k * p[3];
    return 16'(sum / (n * n * n));
  endfunction

  // Apply one accepted beat to the predicted state; queue its point, if any.
  task automatic predict_point(input path_req_t r);
    logic [10:0] n;
    path_point_t pt;
    n = steps_reg < STEPS_MIN ? STEPS_MIN : (steps_reg > STEPS_MAX ? STEPS_MAX : steps_reg);
    if (!r.is_next) begin
      cp_x[0] = r.sx;  cp_y[0] = r.sy;
      cp_x[1] = r.c1x; cp_y[1] = r.c1y;
      step_k = '0;
    end else begin
      step_k = step_k + 11'd1;
      if (step_k == n) begin
        pt.x = cp_x[3]; pt.y = cp_y[3]; pt.seg_end = 1'b1;
        point_q.push_back(pt);
        return;
      end
      if (step_k < n) begin
        pt.x = bezier_axis(cp_x, n, step_k);
        pt.y = bezier_axis(cp_y, n, step_k);
        pt.seg_end = 1'b0;
        point_q.push_back(pt);
        return;
      end
      // Past the end point: chain a new segment starting at the old end.
      cp_x[0] = cp_x[3]; cp_y[0] = cp_y[3];
      cp_x[1] = cp_x[4]; cp_y[1] = cp_y[4];
      step_k = 11'd1;
    end
    cp_x[2] = r.c2x; cp_y[2] = r.c2y;
    cp_x[4] = r.fx;  cp_y[4] = r.fy;
    cp_x[3] = 16'(({1'b0, r.c2x} + {1'b0, r.fx}) >> 1);
    cp_y[3] = 16'(({1'b0, r.c2y} + {1'b0, r.fy}) >> 1);
    if (r.is_next) begin
      pt.x = bezier_axis(cp_x, n, step_k);
      pt.y = bezier_axis(cp_y, n, step_k);
      pt.seg_end = 1'b0;
      point_q.push_back(pt);
    end
  endtask

  // Driver: predicts each beat as it is taken, then presents the next one.
  always @(posedge clk) begin
    path_req_t r;
    logic present;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        r = req_q.pop_front();
        predict_point(r);
        if (!r.is_next) starts_sent++;
      end
      if (s_tvalid && !s_tready) begin
        present = 1'b1;
      end else begin
        present = req_q.size() != 0 && $urandom_range(99) >= sender_idle;
        if (present && req_q[0].hold && point_q.size() != 0) present = 1'b0;
      end
      s_tvalid <= present;
      if (present) begin
        r = req_q[0];
        s_tuser <= r.is_next;
        s_tdata <= {r.fy, r.fx, r.c2y, r.c2x, r.c1y, r.c1x, r.sy, r.sx};
      end
      m_tready <= $urandom_range(99) >= receiver_idle;
    end
  end

  // Monitor: every result beat is checked against the oldest predicted point.
  always @(posedge clk) begin
    path_point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (point_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point beat %h/%b", m_tdata, m_tuser);
      end else begin
        want = point_q.pop_front();
        points_seen++;
        if (m_tuser) ends_seen++;
        if (m_tdata[15:0] !== want.x || m_tdata[31:16] !== want.y
            || m_tuser !== want.seg_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: expected x=%h y=%h end=%b, got x=%h y=%h end=%b",
                     want.x, want.y, want.seg_end, m_tdata[15:0], m_tdata[31:16], m_tuser);
        end
      end
    end
  end

  function automatic logic [15:0] coord_value();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic path_req_t make_req(input logic is_next);
    path_req_t r;
    r.is_next = is_next;
    r.sx = coord_value(); r.sy = coord_value();
    r.c1x = coord_value(); r.c1y = coord_value();
    r.c2x = coord_value(); r.c2y = coord_value();
    r.fx = coord_value(); r.fy = coord_value();
    r.hold = 1'b0;
    return r;
  endfunction

  function automatic path_req_t fill_req(input logic is_next, input logic [15:0] v);
    path_req_t r;
    r = '{is_next, v, v, v, v, v, v, v, v, 1'b0};
    return r;
  endfunction

  // Wait until nothing is pending, then let an in-flight start beat settle.
  task automatic wait_idle();
    while (req_q.size() != 0 || s_tvalid || point_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Register write with a setup and an access phase; only issued while the unit is idle.
  task automatic write_steps(input logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= value; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    steps_reg = value[10:0];
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] step_cfg[10] = '{32'd0, 32'd1024, 32'd2047, 32'd5, 32'd1, 32'd17,
                                  32'd2, 32'd100, 32'd3, 32'd32};
    path_req_t r;
    for (int i = 0; i < 5; i++) begin
      cp_x[i] = '0; cp_y[i] = '0;
    end
    step_k = '0;
    steps_reg = STEPS_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: next points before any start walk the all-zero points at
    // the reset step count.
    req_q.push_back(fill_req(1'b1, 16'h0000));
    req_q.push_back(fill_req(1'b1, 16'hFFFF));
    wait_idle();
    write_steps(32'd3);
    // Full-scale start, then walk past the end point into a chained segment.
    req_q.push_back(fill_req(1'b0, 16'hFFFF));
    for (int i = 0; i < 5; i++) req_q.push_back(fill_req(1'b1, 16'h0000));
    req_q.push_back(fill_req(1'b0, 16'h0000));
    req_q.push_back(fill_req(1'b1, 16'hFFFF));
    req_q.push_back(make_req(1'b0));
    for (int i = 0; i < 4; i++) req_q.push_back(make_req(1'b1));
    wait_idle();
    // A start at N = 1024 (2047 saturates), then lowering N mid-segment chains a new segment on the next request.
    write_steps(32'd2047);
    req_q.push_back(make_req(1'b0));
    for (int i = 0; i < 3; i++) req_q.push_back(make_req(1'b1));
    wait_idle();
    write_steps(32'd2);
    for (int i = 0; i < 3; i++) req_q.push_back(make_req(1'b1));
    wait_idle();

    // Random part: mostly long runs of next requests, with occasional restarts.
    for (int p = 0; p < 10; p++) begin
      sender_idle = p < 4 ? 24 : (p < 7 ? 83 : 0);
      receiver_idle = p < 4 ? 83 : (p < 7 ? 24 : 0);
      write_steps(step_cfg[p]);
      for (int i = 0; i < 80; i++) begin
        r = make_req($urandom_range(9) != 0);
        r.hold = $urandom_range(29) == 0;
        req_q.push_back(r);
      end
      wait_idle();
    end

    $display("Checked %0d points (%0d segment ends) over %0d path starts,", points_seen,
             ends_seen, starts_sent);
    $display("across step counts from below 2 to above 1024 and three stall patterns.");
    if (mismatches == 0 && point_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bppg_pkg.sv
rtl/core/bppg_ctrl.sv
rtl/core/bppg_dp.sv
rtl/core/bezier_path_point_generator_unit.sv
test/tb.sv
